[hdl/tabc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabc_pkg
// Shared constants for the threshold alarm blink controller: register
// indexes, register widths and reset values, default parameter values.
// ----------------------------------------------------------------------------
package tabc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 10;
   localparam int LAMP_WIDTH_DEFAULT  = 16;

   localparam int THRESHOLD_BITS = 10;
   localparam int PHASE_BITS     = 5;
   localparam int BLINK_BITS     = 4;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALARM_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_TICKS     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLINK_CYCLES    = 2'd2;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 10'd511;
   localparam logic [PHASE_BITS-1:0]     PHASE_RESET     = 5'd25;
   localparam logic [BLINK_BITS-1:0]     BLINK_RESET     = 4'd8;

endpackage

[hdl/threshold_alarm_blink_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_alarm_blink_controller
// Threshold alarm with a blinking warning phase, one polling tick per item.
// ----------------------------------------------------------------------------
// Each item is one polling tick and yields exactly one result item holding the
// lamp pattern and alarm flags after that tick. The state update is one pass
// of compares and small counter increments between the input handshake and a
// result register, so an item is taken every cycle and its result appears on
// the next cycle; the only limit on rate is the result register, which holds
// a result that is stalled while still taking the next item into the state
// once it drains. Configuration writes are taken on any cycle with csr_write_en
// high; writes to an index past the last register are dropped.
// ----------------------------------------------------------------------------
module threshold_alarm_blink_controller #(
   parameter int SAMPLE_BITS = tabc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int LAMP_WIDTH  = tabc_pkg::LAMP_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write_en,
   input  logic [tabc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tabc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   // tick items
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [SAMPLE_BITS-1:0]             req_sample,
   input  logic                               req_sample_valid,
   input  logic                               req_button_now,
   input  logic                               req_button_recheck,
   // result items
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [LAMP_WIDTH-1:0]              rsp_lamp_pattern,
   output logic                               rsp_alarm_active,
   output logic                               rsp_in_sequence
);

   localparam int CMP_BITS = (SAMPLE_BITS > tabc_pkg::THRESHOLD_BITS) ?
                             SAMPLE_BITS : tabc_pkg::THRESHOLD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ON,
      ST_OFF,
      ST_CHECK,
      ST_LATCHED
   } state_type;

   state_type                            state_ff, state_in;
   logic [tabc_pkg::THRESHOLD_BITS-1:0]  threshold_ff;
   logic [tabc_pkg::PHASE_BITS-1:0]      phase_ticks_ff;
   logic [tabc_pkg::BLINK_BITS-1:0]      blink_cycles_ff;
   logic [tabc_pkg::PHASE_BITS-1:0]      phase_cnt_ff, phase_cnt_in;
   logic [tabc_pkg::BLINK_BITS-1:0]      blink_cnt_ff, blink_cnt_in;
   logic                                 prev_pressed_ff, prev_pressed_in;

   logic                                 rsp_valid_ff;
   logic [LAMP_WIDTH-1:0]                lamp_ff, lamp_in;
   logic                                 alarm_ff;
   logic                                 in_seq_ff;

   logic                                 accept;
   logic [CMP_BITS-1:0]                  sample_ext;
   logic [CMP_BITS-1:0]                  threshold_ext;
   logic                                 below;
   logic                                 above;
   logic                                 confirmed;
   logic                                 press_edge;
   logic [tabc_pkg::PHASE_BITS-1:0]      phase_lim;
   logic [tabc_pkg::BLINK_BITS-1:0]      blink_lim;
   logic                                 phase_done;
   logic [tabc_pkg::BLINK_BITS-1:0]      blink_next;
   logic                                 blink_done;

   // result register frees up when it drains in the same cycle
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign sample_ext    = CMP_BITS'(req_sample);
   assign threshold_ext = CMP_BITS'(threshold_ff);
   assign below         = req_sample_valid & (sample_ext < threshold_ext);
   assign above         = sample_ext > threshold_ext;
   assign confirmed     = req_button_now & req_button_recheck;
   assign press_edge    = ~prev_pressed_ff & confirmed;

   // zero settings behave as one
   assign phase_lim  = (phase_ticks_ff == '0) ? tabc_pkg::PHASE_BITS'(1) : phase_ticks_ff;
   assign blink_lim  = (blink_cycles_ff == '0) ? tabc_pkg::BLINK_BITS'(1) : blink_cycles_ff;
   assign phase_done = ({1'b0, phase_cnt_ff} + (tabc_pkg::PHASE_BITS+1)'(1)) >=
                       {1'b0, phase_lim};
   assign blink_next = blink_cnt_ff + tabc_pkg::BLINK_BITS'(1);
   assign blink_done = (blink_next == '0) || (blink_next >= blink_lim);

   always_comb begin
      state_in        = state_ff;
      phase_cnt_in    = phase_cnt_ff;
      blink_cnt_in    = blink_cnt_ff;
      prev_pressed_in = prev_pressed_ff;
      unique case (state_ff)
         ST_ON, ST_OFF: begin
            if (below || confirmed) begin
               state_in     = ST_IDLE;
               phase_cnt_in = '0;
               blink_cnt_in = '0;
            end else if (phase_done) begin
               phase_cnt_in = '0;
               if (state_ff == ST_ON) begin
                  state_in = ST_OFF;
               end else begin
                  blink_cnt_in = blink_next;
                  state_in     = blink_done ? ST_CHECK : ST_ON;
               end
            end else begin
               phase_cnt_in = phase_cnt_ff + tabc_pkg::PHASE_BITS'(1);
            end
         end
         ST_CHECK: begin
            // buttons are not looked at on the final check
            state_in     = (req_sample_valid && !above && !below && 1'b1) ||
                           (req_sample_valid && above) ? ST_LATCHED : ST_IDLE;
            phase_cnt_in = '0;
            blink_cnt_in = '0;
         end
         ST_IDLE, ST_LATCHED: begin
            if (req_sample_valid) begin
               prev_pressed_in = req_button_now;
               // a press edge clears a latched alarm before the threshold test
               if ((state_ff == ST_IDLE || press_edge) && above) begin
                  state_in     = ST_ON;
                  phase_cnt_in = '0;
                  blink_cnt_in = '0;
               end else if (below || press_edge) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      unique case (state_in)
         ST_ON:      lamp_in = LAMP_WIDTH'(1);
         ST_LATCHED: lamp_in = '1;
         default:    lamp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= tabc_pkg::THRESHOLD_RESET;
         phase_ticks_ff  <= tabc_pkg::PHASE_RESET;
         blink_cycles_ff <= tabc_pkg::BLINK_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tabc_pkg::CSR_ALARM_THRESHOLD:
               threshold_ff <= csr_wdata[tabc_pkg::THRESHOLD_BITS-1:0];
            tabc_pkg::CSR_PHASE_TICKS:
               phase_ticks_ff <= csr_wdata[tabc_pkg::PHASE_BITS-1:0];
            tabc_pkg::CSR_BLINK_CYCLES:
               blink_cycles_ff <= csr_wdata[tabc_pkg::BLINK_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         phase_cnt_ff    <= '0;
         blink_cnt_ff    <= '0;
         prev_pressed_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            state_ff        <= state_in;
            phase_cnt_ff    <= phase_cnt_in;
            blink_cnt_ff    <= blink_cnt_in;
            prev_pressed_ff <= prev_pressed_in;
            rsp_valid_ff    <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lamp_ff   <= lamp_in;
         alarm_ff  <= (state_in != ST_IDLE);
         in_seq_ff <= (state_in == ST_ON) || (state_in == ST_OFF) || (state_in == ST_CHECK);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lamp_pattern = lamp_ff;
   assign rsp_alarm_active = alarm_ff;
   assign rsp_in_sequence  = in_seq_ff;

endmodule

[hdl/tabc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabc_checker
// Port-level checks for the threshold alarm blink controller.
// ----------------------------------------------------------------------------
module tabc_checker #(
   parameter int LAMP_WIDTH  = tabc_pkg::LAMP_WIDTH_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [LAMP_WIDTH-1:0] rsp_lamp_pattern,
   input logic                  rsp_alarm_active,
   input logic                  rsp_in_sequence
);

   // every item gives a result on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item produced no result");

   // a stalled result is held
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_lamp_pattern) &&
                                    $stable(rsp_alarm_active) && $stable(rsp_in_sequence)))
      else $error("stalled result changed");

   a_lamp_needs_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_lamp_pattern != '0 || rsp_in_sequence)) |-> rsp_alarm_active)
      else $error("lamp or sequence without alarm");

   a_sequence_lamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_sequence) |->
         (rsp_lamp_pattern == '0 || rsp_lamp_pattern == LAMP_WIDTH'(1)))
      else $error("sequence lamp pattern not blink lamp");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind threshold_alarm_blink_controller tabc_checker #(
   .LAMP_WIDTH (LAMP_WIDTH)
) u_tabc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_lamp_pattern(rsp_lamp_pattern),
   .rsp_alarm_active(rsp_alarm_active),
   .rsp_in_sequence (rsp_in_sequence)
);

[verif/tb_threshold_alarm_blink_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_alarm_blink_controller
// Self-checking bench for the threshold alarm blink controller. Ticks are
// sent in random bursts, and each tick is fed to a cycle-free model of the
// alarm state machine. Every result item is compared with the model's
// oldest prediction while the result side stalls on a pattern of its own.
// A short directed run covers the edge cases. Random phases follow, each
// with its own register setting.
// ----------------------------------------------------------------------------
module tb_threshold_alarm_blink_controller;

   localparam int SAMPLE_W   = tabc_pkg::SAMPLE_BITS_DEFAULT;
   localparam int LAMP_W     = tabc_pkg::LAMP_WIDTH_DEFAULT;
   localparam int THR_W      = tabc_pkg::THRESHOLD_BITS;
   localparam int PHASE_W    = tabc_pkg::PHASE_BITS;
   localparam int BLINK_W    = tabc_pkg::BLINK_BITS;
   localparam int IDX_W      = tabc_pkg::CSR_INDEX_BITS;
   localparam int DATA_W     = tabc_pkg::CSR_DATA_BITS;
   localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
   localparam logic [IDX_W-1:0] CSR_UNUSED_INDEX = IDX_W'(3);
   localparam int NUM_PHASES = 9;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ON,
      MODE_OFF,
      MODE_END
   } blink_mode_type;

   typedef enum int {
      STAGE_REST,
      STAGE_BLINK,
      STAGE_CHECK
   } tick_stage_type;

   typedef struct packed {
      logic [LAMP_W-1:0] lamp;
      logic              alarm;
      logic              in_seq;
   } lamp_result_type;

   class lamp_tracker;
      logic [THR_W-1:0]          threshold;
      logic [PHASE_W-1:0]        phase_ticks;
      logic [BLINK_W-1:0]        blink_cycles;
      blink_mode_type            mode;
      bit                        alarm_flag;
      bit                        prev_pressed;
      logic [PHASE_W-1:0]        phase_cnt;
      logic [BLINK_W-1:0]        blink_cnt;
      logic [LAMP_W-1:0]         lamp;
      lamp_result_type           lamp_expect_q[$];
      int                        ticks_taken;
      int                        results_checked;
      int                        mismatches;

      function new();
         threshold       = tabc_pkg::THRESHOLD_RESET;
         phase_ticks     = tabc_pkg::PHASE_RESET;
         blink_cycles    = tabc_pkg::BLINK_RESET;
         prev_pressed    = 0;
         ticks_taken     = 0;
         results_checked = 0;
         mismatches      = 0;
         go_idle();
      endfunction

      function void go_idle();
         mode       = MODE_IDLE;
         alarm_flag = 0;
         lamp       = '0;
         phase_cnt  = '0;
         blink_cnt  = '0;
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
         case (idx)
            tabc_pkg::CSR_ALARM_THRESHOLD: threshold    = data[THR_W-1:0];
            tabc_pkg::CSR_PHASE_TICKS:     phase_ticks  = data[PHASE_W-1:0];
            tabc_pkg::CSR_BLINK_CYCLES:    blink_cycles = data[BLINK_W-1:0];
            default: ;
         endcase
      endfunction

      function tick_stage_type stage();
         if (mode == MODE_ON || mode == MODE_OFF) return STAGE_BLINK;
         if (mode == MODE_END && lamp == '0) return STAGE_CHECK;
         return STAGE_REST;
      endfunction

      function void take_tick(logic [SAMPLE_W-1:0] smp, bit valid, bit now, bit recheck);
         int              pt;
         int              bc;
         bit              confirmed;
         lamp_result_type res;
         pt = (phase_ticks == '0) ? 1 : int'(phase_ticks);
         bc = (blink_cycles == '0) ? 1 : int'(blink_cycles);
         confirmed = now && recheck;
         ticks_taken++;

         if (mode == MODE_ON || mode == MODE_OFF) begin
            if ((valid && smp < threshold) || confirmed) begin
               go_idle();
            end else if (int'(phase_cnt) + 1 >= pt) begin
               phase_cnt = '0;
               if (mode == MODE_ON) begin
                  mode = MODE_OFF;
                  lamp = '0;
               end else begin
                  blink_cnt = blink_cnt + 1'b1;
                  if (blink_cnt == '0 || int'(blink_cnt) >= bc) begin
                     mode = MODE_END;
                     lamp = '0;
                  end else begin
                     mode = MODE_ON;
                     lamp = LAMP_W'(1);
                  end
               end
            end else begin
               phase_cnt = phase_cnt + 1'b1;
            end
         end else if (mode == MODE_END && lamp == '0) begin
            // final check tick, buttons not looked at
            if (valid && smp >= threshold) begin
               lamp       = '1;
               alarm_flag = 1;
               phase_cnt  = '0;
               blink_cnt  = '0;
            end else begin
               go_idle();
            end
         end else if (valid) begin
            // press edge is taken before the threshold test
            if (!prev_pressed && confirmed) go_idle();
            prev_pressed = now;
            if (!alarm_flag && smp > threshold) begin
               mode       = MODE_ON;
               alarm_flag = 1;
               lamp       = LAMP_W'(1);
               phase_cnt  = '0;
               blink_cnt  = '0;
            end else if (alarm_flag && smp < threshold) begin
               go_idle();
            end
         end

         res.lamp   = lamp;
         res.alarm  = alarm_flag;
         res.in_seq = (stage() != STAGE_REST);
         lamp_expect_q.push_back(res);
      endfunction

      function void check_result(logic [LAMP_W-1:0] got_lamp, logic got_alarm, logic got_seq);
         lamp_result_type want;
         if (lamp_expect_q.size() == 0) begin
            $error("result item with no tick pending: lamp_pattern=%h", got_lamp);
            mismatches++;
            return;
         end
         want = lamp_expect_q.pop_front();
         results_checked++;
         if (got_lamp !== want.lamp) begin
            $error("lamp_pattern: expected %h, actual %h", want.lamp, got_lamp);
            mismatches++;
         end
         if (got_alarm !== want.alarm) begin
            $error("alarm_active: expected %b, actual %b", want.alarm, got_alarm);
            mismatches++;
         end
         if (got_seq !== want.in_seq) begin
            $error("in_sequence: expected %b, actual %b", want.in_seq, got_seq);
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_en = 1'b0;
   logic [IDX_W-1:0]          csr_index = '0;
   logic [DATA_W-1:0]         csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_W-1:0]       req_sample = '0;
   logic                      req_sample_valid = 1'b0;
   logic                      req_button_now = 1'b0;
   logic                      req_button_recheck = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [LAMP_W-1:0]         rsp_lamp_pattern;
   logic                      rsp_alarm_active;
   logic                      rsp_in_sequence;

   lamp_tracker sb;
   int          burst_left = 0;
   int          stall_left = 0;
   int          stall_style = 0;
   int          settings_used = 0;

   // random phases: threshold, phase ticks, blink cycles, item count
   int phase_thr [NUM_PHASES] = '{511, 0, 1023, 300, 700, 100, 900, 450, 600};
   int phase_pt  [NUM_PHASES] = '{25, 1, 3, 2, 1, 31, 0, 4, 31};
   int phase_bc  [NUM_PHASES] = '{8, 1, 2, 3, 15, 1, 0, 5, 15};
   int phase_cnt [NUM_PHASES] = '{80, 80, 80, 80, 80, 80, 80, 80, 1000};

   threshold_alarm_blink_controller dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_sample_valid   (req_sample_valid),
      .req_button_now     (req_button_now),
      .req_button_recheck (req_button_recheck),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_lamp_pattern   (rsp_lamp_pattern),
      .rsp_alarm_active   (rsp_alarm_active),
      .rsp_in_sequence    (rsp_in_sequence)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side stall, switching between random styles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 120);
         end else begin
            stall_left--;
         end
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (stall_left % 7 < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_lamp_pattern, rsp_alarm_active, rsp_in_sequence);
   end

   task automatic send_tick(input logic [SAMPLE_W-1:0] smp, input bit valid,
                            input bit now, input bit recheck);
      req_valid          <= 1'b1;
      req_sample         <= smp;
      req_sample_valid   <= valid;
      req_button_now     <= now;
      req_button_recheck <= recheck;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_tick(smp, valid, now, recheck);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.lamp_expect_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      sb.set_reg(idx, data);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_alarm_config(input int thr, input int pt, input int bc);
      // junk in the unused upper data bits must be dropped
      write_reg(tabc_pkg::CSR_ALARM_THRESHOLD, DATA_W'(thr));
      write_reg(tabc_pkg::CSR_PHASE_TICKS,
                DATA_W'(pt | ($urandom_range(0, 31) << PHASE_W)));
      write_reg(tabc_pkg::CSR_BLINK_CYCLES,
                DATA_W'(bc | ($urandom_range(0, 63) << BLINK_W)));
      write_reg(CSR_UNUSED_INDEX, DATA_W'($urandom_range(0, 1023)));
      settings_used++;
   endtask

   task automatic run_random(input int count);
      logic [SAMPLE_W-1:0] smp;
      logic [SAMPLE_W-1:0] high;
      bit                  valid;
      bit                  now;
      bit                  recheck;
      for (int n = 0; n < count; n++) begin
         now     = 1'($urandom_range(0, 1));
         recheck = 1'($urandom_range(0, 1));
         valid   = 1'($urandom_range(0, 1));
         smp     = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
         high    = SAMPLE_W'($urandom_range(SAMPLE_MAX, sb.threshold));
         // about one tick in ten is plain noise
         if ($urandom_range(0, 9) != 0) begin
            case (sb.stage())
               STAGE_BLINK: begin
                  valid = ($urandom_range(0, 9) != 0);
                  smp   = ($urandom_range(0, 99) < 96) ? high
                          : SAMPLE_W'($urandom_range(sb.threshold, 0));
                  if ($urandom_range(0, 99) >= 3) recheck = recheck & ~now;
               end
               STAGE_CHECK: begin
                  valid = ($urandom_range(0, 9) != 0);
                  if ($urandom_range(0, 4) != 0) smp = high;
               end
               default: begin
                  valid = ($urandom_range(0, 7) != 0);
                  if ($urandom_range(0, 1) != 0) smp = high;
                  if ($urandom_range(0, 3) != 0) recheck = recheck & ~now;
               end
            endcase
         end
         send_tick(smp, valid, now, recheck);
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      settings_used = 1;

      // reset setting: invalid ignored, threshold equality, cancel paths
      send_tick(SAMPLE_W'(SAMPLE_MAX), 1'b0, 1'b0, 1'b0);
      send_tick('0, 1'b1, 1'b0, 1'b0);
      send_tick(10'd511, 1'b1, 1'b0, 1'b0);
      send_tick(10'd512, 1'b1, 1'b0, 1'b0);
      send_tick('0, 1'b0, 1'b1, 1'b0);
      send_tick(10'd600, 1'b1, 1'b0, 1'b1);
      send_tick(10'd600, 1'b1, 1'b1, 1'b1);
      send_tick(SAMPLE_W'(SAMPLE_MAX), 1'b1, 1'b0, 1'b0);
      send_tick(10'd510, 1'b1, 1'b0, 1'b0);

      // zero threshold, single short blink, latch then press edge
      drain_results();
      set_alarm_config(0, 1, 1);
      send_tick(SAMPLE_W'(SAMPLE_MAX), 1'b1, 1'b0, 1'b0);
      send_tick('0, 1'b1, 1'b0, 1'b0);
      send_tick('0, 1'b1, 1'b0, 1'b0);
      send_tick('0, 1'b1, 1'b1, 1'b1);
      send_tick(10'd5, 1'b0, 1'b1, 1'b1);
      send_tick('0, 1'b1, 1'b1, 1'b1);
      send_tick(SAMPLE_W'(SAMPLE_MAX), 1'b1, 1'b1, 1'b1);

      // top threshold, which no sample can exceed, with zero counts
      drain_results();
      set_alarm_config(1023, 0, 0);
      send_tick(SAMPLE_W'(SAMPLE_MAX), 1'b1, 1'b0, 1'b0);
      send_tick(SAMPLE_W'(SAMPLE_MAX), 1'b1, 1'b0, 1'b0);
      send_tick(10'd1022, 1'b1, 1'b0, 1'b0);
      send_tick(SAMPLE_W'(SAMPLE_MAX), 1'b1, 1'b0, 1'b0);

      // latched alarm released by a low sample
      drain_results();
      set_alarm_config(511, 1, 1);
      send_tick(10'd800, 1'b1, 1'b0, 1'b0);
      send_tick(10'd800, 1'b1, 1'b0, 1'b0);
      send_tick(10'd800, 1'b1, 1'b0, 1'b0);
      send_tick(10'd800, 1'b1, 1'b0, 1'b0);
      send_tick(10'd100, 1'b1, 1'b0, 1'b0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         set_alarm_config(phase_thr[p], phase_pt[p], phase_bc[p]);
         run_random(phase_cnt[p]);
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.lamp_expect_q.size() != 0) begin
         $error("%0d result items never arrived", sb.lamp_expect_q.size());
         sb.mismatches++;
      end
      $display("run covered %0d ticks under %0d register settings", sb.ticks_taken,
               settings_used);
      $display("%0d result items checked, %0d field mismatches", sb.results_checked,
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d result items outstanding", sb.lamp_expect_q.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
